### design/skte_pkg.sv
// Shared types, constants and codes for the sorted key table engine.
`default_nettype none

package skte_pkg;

    localparam int TABLE_SIZE = 16;
    localparam int IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int CNT_W      = IDX_W + 1;
    localparam int KEY_W      = 31;
    localparam int PAY_W      = 32;
    localparam int SLOT_W     = 4;
    localparam int ENTRY_W    = KEY_W + PAY_W;

    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [PAY_W-1:0]   pay_t;
    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [ENTRY_W-1:0] entry_t;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_SORT   = 2'd2;
    localparam logic [1:0] CMD_FIND   = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    typedef struct packed {
        logic [1:0] command;
        key_t       key;
        pay_t       payload;
    } in_beat_t;

    typedef struct packed {
        logic [1:0] status;
        slot_t      slot_index;
        key_t       found_key;
        pay_t       found_payload;
    } out_beat_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_FIND_RD,
        S_FIND_CHK,
        S_SORT_RD_I,
        S_SORT_CUR,
        S_SORT_RD_J,
        S_SORT_CMP,
        S_FINISH
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLEAR,
        OP_RES_OK,
        OP_RES_FULL,
        OP_RES_MISS,
        OP_SCAN_RD,
        OP_SCAN_NEXT,
        OP_INS_WR,
        OP_FIND_RD,
        OP_FIND_HIT,
        OP_FIND_LO,
        OP_FIND_HI,
        OP_SORT_RD_I,
        OP_SORT_CUR,
        OP_SORT_RD_J,
        OP_SORT_SWAP,
        OP_SORT_KEEP,
        OP_SORT_WR_I,
        OP_PUSH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       key_zero;
        logic       scan_end;
        logic       sort_done;
        logic       j_end;
        logic       search_end;
        logic       rd_zero;
        logic       rd_eq;
        logic       rd_lt;
        logic       swap;
        logic       out_free;
    } ctrl_stat_t;

endpackage

`default_nettype wire

### design/skte_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module skte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### design/skte_datapath.sv
// Datapath: table RAM, slot valid bits, loop counters, result and output beat registers.
`default_nettype none

module skte_datapath (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire skte_pkg::ctrl_cmd_t  ctrl_cmd,
    output skte_pkg::ctrl_stat_t      ctrl_stat,
    input  wire skte_pkg::in_beat_t   s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output skte_pkg::out_beat_t       m_data
);

    skte_pkg::dp_op_t op;
    assign op = ctrl_cmd.op;

    logic [1:0]        cmd_reg;
    skte_pkg::key_t    key_reg;
    skte_pkg::pay_t    pay_reg;
    skte_pkg::cnt_t    i_reg;
    skte_pkg::cnt_t    j_reg;
    skte_pkg::cnt_t    lo_reg;
    skte_pkg::cnt_t    hi1_reg;
    skte_pkg::key_t    cur_key_reg;
    skte_pkg::pay_t    cur_pay_reg;
    logic [skte_pkg::TABLE_SIZE-1:0] valid_reg;
    logic              rd_valid_reg;
    skte_pkg::out_beat_t res_reg;
    skte_pkg::out_beat_t out_reg;
    logic              out_valid_reg;

    logic [skte_pkg::CNT_W:0] mid_sum;
    skte_pkg::cnt_t    mid;
    skte_pkg::entry_t  rd_data;
    skte_pkg::key_t    rd_key;
    skte_pkg::pay_t    rd_pay;
    logic              rd_en;
    skte_pkg::idx_t    rd_idx;
    logic              wr_en;
    skte_pkg::idx_t    wr_idx;
    skte_pkg::entry_t  wr_data;

    // (lo + hi) / 2 with hi1 = hi + 1; only used while lo < hi1
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi1_reg} - {{skte_pkg::CNT_W{1'b0}}, 1'b1};
    assign mid     = mid_sum[skte_pkg::CNT_W:1];

    assign rd_key = rd_valid_reg ? rd_data[skte_pkg::ENTRY_W-1:skte_pkg::PAY_W] : '0;
    assign rd_pay = rd_data[skte_pkg::PAY_W-1:0];

    always_comb begin
        rd_en = 1'b1;
        unique case (op)
            skte_pkg::OP_SCAN_RD,
            skte_pkg::OP_SORT_RD_I: rd_idx = i_reg[skte_pkg::IDX_W-1:0];
            skte_pkg::OP_FIND_RD:   rd_idx = mid[skte_pkg::IDX_W-1:0];
            skte_pkg::OP_SORT_RD_J: rd_idx = j_reg[skte_pkg::IDX_W-1:0];
            default: begin
                rd_en  = 1'b0;
                rd_idx = i_reg[skte_pkg::IDX_W-1:0];
            end
        endcase
    end

    always_comb begin
        wr_en = 1'b1;
        unique case (op)
            skte_pkg::OP_INS_WR: begin
                wr_idx  = i_reg[skte_pkg::IDX_W-1:0];
                wr_data = {key_reg, pay_reg};
            end
            skte_pkg::OP_SORT_SWAP: begin
                wr_idx  = j_reg[skte_pkg::IDX_W-1:0];
                wr_data = {cur_key_reg, cur_pay_reg};
            end
            skte_pkg::OP_SORT_WR_I: begin
                wr_idx  = i_reg[skte_pkg::IDX_W-1:0];
                wr_data = {cur_key_reg, cur_pay_reg};
            end
            default: begin
                wr_en   = 1'b0;
                wr_idx  = i_reg[skte_pkg::IDX_W-1:0];
                wr_data = {cur_key_reg, cur_pay_reg};
            end
        endcase
    end

    skte_ram #(
        .WIDTH (skte_pkg::ENTRY_W),
        .DEPTH (skte_pkg::TABLE_SIZE)
    ) u_table_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_idx),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_idx),
        .rd_data (rd_data)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_idx];
            end
            if (op == skte_pkg::OP_CLEAR) begin
                valid_reg <= '0;
            end else if (wr_en) begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (op == skte_pkg::OP_PUSH) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        unique case (op)
            skte_pkg::OP_LOAD: begin
                cmd_reg <= s_data.command;
                key_reg <= s_data.key;
                pay_reg <= s_data.payload;
                i_reg   <= '0;
                lo_reg  <= '0;
                hi1_reg <= skte_pkg::cnt_t'(skte_pkg::TABLE_SIZE);
            end
            skte_pkg::OP_CLEAR,
            skte_pkg::OP_RES_OK: begin
                res_reg <= '{status: skte_pkg::ST_OK, default: '0};
            end
            skte_pkg::OP_RES_FULL: begin
                res_reg <= '{status: skte_pkg::ST_FULL, default: '0};
            end
            skte_pkg::OP_RES_MISS: begin
                res_reg <= '{status: skte_pkg::ST_MISS, default: '0};
            end
            skte_pkg::OP_SCAN_NEXT: begin
                i_reg <= i_reg + 1'b1;
            end
            skte_pkg::OP_INS_WR: begin
                res_reg.status        <= skte_pkg::ST_OK;
                res_reg.slot_index    <= skte_pkg::slot_t'(i_reg);
                res_reg.found_key     <= key_reg;
                res_reg.found_payload <= '0;
            end
            skte_pkg::OP_FIND_HIT: begin
                res_reg.status        <= skte_pkg::ST_OK;
                res_reg.slot_index    <= skte_pkg::slot_t'(mid);
                res_reg.found_key     <= rd_key;
                res_reg.found_payload <= rd_pay;
            end
            skte_pkg::OP_FIND_LO: begin
                lo_reg <= mid + 1'b1;
            end
            skte_pkg::OP_FIND_HI: begin
                hi1_reg <= mid;
            end
            skte_pkg::OP_SORT_CUR: begin
                cur_key_reg <= rd_key;
                cur_pay_reg <= rd_pay;
                j_reg       <= i_reg + 1'b1;
            end
            skte_pkg::OP_SORT_SWAP: begin
                cur_key_reg <= rd_key;
                cur_pay_reg <= rd_pay;
                j_reg       <= j_reg + 1'b1;
            end
            skte_pkg::OP_SORT_KEEP: begin
                j_reg <= j_reg + 1'b1;
            end
            skte_pkg::OP_SORT_WR_I: begin
                i_reg <= i_reg + 1'b1;
            end
            skte_pkg::OP_PUSH: begin
                out_reg <= res_reg;
            end
            default: begin
            end
        endcase
    end

    assign ctrl_stat.cmd        = cmd_reg;
    assign ctrl_stat.key_zero   = (key_reg == '0);
    assign ctrl_stat.scan_end   = (i_reg == skte_pkg::cnt_t'(skte_pkg::TABLE_SIZE));
    assign ctrl_stat.sort_done  = (i_reg == skte_pkg::cnt_t'(skte_pkg::TABLE_SIZE - 1));
    assign ctrl_stat.j_end      = (j_reg == skte_pkg::cnt_t'(skte_pkg::TABLE_SIZE));
    assign ctrl_stat.search_end = (lo_reg >= hi1_reg);
    assign ctrl_stat.rd_zero    = (rd_key == '0);
    assign ctrl_stat.rd_eq      = (rd_key == key_reg);
    assign ctrl_stat.rd_lt      = (rd_key < key_reg);
    assign ctrl_stat.swap       = (cur_key_reg > rd_key);
    assign ctrl_stat.out_free   = !out_valid_reg || m_ready;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_push_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == skte_pkg::OP_PUSH) |-> (!out_valid_reg || m_ready))
        else $error("result beat overwritten before it was taken");

    a_find_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == skte_pkg::OP_FIND_RD) |-> (lo_reg < hi1_reg))
        else $error("binary search probe outside its window");

    a_sort_j_above_i: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == skte_pkg::OP_SORT_RD_J) |-> (j_reg > i_reg))
        else $error("sort inner index not above outer index");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == skte_pkg::OP_CLEAR) |=> (valid_reg == '0))
        else $error("clear left a slot marked written");

endmodule

`default_nettype wire

### design/skte_ctrl.sv
// Controller state machine: sequences clear, insert scan, exchange sort and binary search.
`default_nettype none

module skte_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire skte_pkg::ctrl_stat_t ctrl_stat,
    output skte_pkg::ctrl_cmd_t       ctrl_cmd
);

    skte_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= skte_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            skte_pkg::S_IDLE: begin
                if (s_valid) state_next = skte_pkg::S_DISPATCH;
            end
            skte_pkg::S_DISPATCH: begin
                unique case (ctrl_stat.cmd)
                    skte_pkg::CMD_CLEAR:  state_next = skte_pkg::S_FINISH;
                    skte_pkg::CMD_INSERT: state_next = skte_pkg::S_SCAN_RD;
                    skte_pkg::CMD_SORT:   state_next = skte_pkg::S_SORT_RD_I;
                    default: begin
                        state_next = ctrl_stat.key_zero ? skte_pkg::S_FINISH
                                                        : skte_pkg::S_FIND_RD;
                    end
                endcase
            end
            skte_pkg::S_SCAN_RD: begin
                state_next = ctrl_stat.scan_end ? skte_pkg::S_FINISH : skte_pkg::S_SCAN_CHK;
            end
            skte_pkg::S_SCAN_CHK: begin
                state_next = ctrl_stat.rd_zero ? skte_pkg::S_FINISH : skte_pkg::S_SCAN_RD;
            end
            skte_pkg::S_FIND_RD: begin
                state_next = ctrl_stat.search_end ? skte_pkg::S_FINISH
                                                  : skte_pkg::S_FIND_CHK;
            end
            skte_pkg::S_FIND_CHK: begin
                state_next = ctrl_stat.rd_eq ? skte_pkg::S_FINISH : skte_pkg::S_FIND_RD;
            end
            skte_pkg::S_SORT_RD_I: begin
                state_next = ctrl_stat.sort_done ? skte_pkg::S_FINISH
                                                 : skte_pkg::S_SORT_CUR;
            end
            skte_pkg::S_SORT_CUR: begin
                state_next = skte_pkg::S_SORT_RD_J;
            end
            skte_pkg::S_SORT_RD_J: begin
                state_next = ctrl_stat.j_end ? skte_pkg::S_SORT_RD_I : skte_pkg::S_SORT_CMP;
            end
            skte_pkg::S_SORT_CMP: begin
                state_next = skte_pkg::S_SORT_RD_J;
            end
            skte_pkg::S_FINISH: begin
                if (ctrl_stat.out_free) state_next = skte_pkg::S_IDLE;
            end
            default: begin
                state_next = skte_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        ctrl_cmd.op = skte_pkg::OP_NONE;
        unique case (state_reg)
            skte_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) ctrl_cmd.op = skte_pkg::OP_LOAD;
            end
            skte_pkg::S_DISPATCH: begin
                unique case (ctrl_stat.cmd)
                    skte_pkg::CMD_CLEAR:  ctrl_cmd.op = skte_pkg::OP_CLEAR;
                    skte_pkg::CMD_INSERT: ctrl_cmd.op = skte_pkg::OP_NONE;
                    skte_pkg::CMD_SORT:   ctrl_cmd.op = skte_pkg::OP_NONE;
                    default: begin
                        ctrl_cmd.op = ctrl_stat.key_zero ? skte_pkg::OP_RES_MISS
                                                         : skte_pkg::OP_NONE;
                    end
                endcase
            end
            skte_pkg::S_SCAN_RD: begin
                ctrl_cmd.op = ctrl_stat.scan_end ? skte_pkg::OP_RES_FULL
                                                 : skte_pkg::OP_SCAN_RD;
            end
            skte_pkg::S_SCAN_CHK: begin
                ctrl_cmd.op = ctrl_stat.rd_zero ? skte_pkg::OP_INS_WR
                                                : skte_pkg::OP_SCAN_NEXT;
            end
            skte_pkg::S_FIND_RD: begin
                ctrl_cmd.op = ctrl_stat.search_end ? skte_pkg::OP_RES_MISS
                                                   : skte_pkg::OP_FIND_RD;
            end
            skte_pkg::S_FIND_CHK: begin
                priority if (ctrl_stat.rd_eq) ctrl_cmd.op = skte_pkg::OP_FIND_HIT;
                else if (ctrl_stat.rd_lt)     ctrl_cmd.op = skte_pkg::OP_FIND_LO;
                else                          ctrl_cmd.op = skte_pkg::OP_FIND_HI;
            end
            skte_pkg::S_SORT_RD_I: begin
                ctrl_cmd.op = ctrl_stat.sort_done ? skte_pkg::OP_RES_OK
                                                  : skte_pkg::OP_SORT_RD_I;
            end
            skte_pkg::S_SORT_CUR: begin
                ctrl_cmd.op = skte_pkg::OP_SORT_CUR;
            end
            skte_pkg::S_SORT_RD_J: begin
                ctrl_cmd.op = ctrl_stat.j_end ? skte_pkg::OP_SORT_WR_I
                                              : skte_pkg::OP_SORT_RD_J;
            end
            skte_pkg::S_SORT_CMP: begin
                ctrl_cmd.op = ctrl_stat.swap ? skte_pkg::OP_SORT_SWAP
                                             : skte_pkg::OP_SORT_KEEP;
            end
            skte_pkg::S_FINISH: begin
                if (ctrl_stat.out_free) ctrl_cmd.op = skte_pkg::OP_PUSH;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

### design/sorted_key_table_engine_top.sv
// Sorted key table engine: one command beat in, one result beat out, one command at a time.
// Clear empties the table. Insert scans the slots in order and writes the first free one, or reports full.
// Find: a binary search of at most log2(N) + 1 probes on one RAM read port.
// Sort: the table is put in ascending key order by an exchange sort.
// The next command is taken once the result sits in the output register.
// Reset clears the slot valid bits; no clearing sweep of the RAM.
`default_nettype none

module sorted_key_table_engine_top (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire skte_pkg::in_beat_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output skte_pkg::out_beat_t      m_data
);

    skte_pkg::ctrl_cmd_t  ctrl_cmd;
    skte_pkg::ctrl_stat_t ctrl_stat;

    skte_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .ctrl_stat (ctrl_stat),
        .ctrl_cmd  (ctrl_cmd)
    );

    skte_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl_cmd  (ctrl_cmd),
        .ctrl_stat (ctrl_stat),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire
